// File: rtl/core/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and codes for the point-in-polygon test block
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_W = 16;
    localparam int COUNT_W = 7;

    // request codes carried by req_type
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // one table entry: x in the low half, y in the high half
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vertex_t;

    // edge handed to the edge unit
    typedef struct packed {
        logic valid;
        logic last;
    } edge_ctl_t;

    // verdict coming back from the edge unit
    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } hit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/pip_ram.sv
// ----------------------------------------------------------------------------
// pip_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/pip_edge.sv
// ----------------------------------------------------------------------------
// pip_edge
// crossing test of one polygon edge against the horizontal ray of a point
// ----------------------------------------------------------------------------
module pip_edge
    import pip_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  edge_ctl_t                 edge_ctl,
    input  vertex_t                   vert_a,
    input  vertex_t                   vert_b,
    input  logic signed [COORD_W-1:0] px,
    input  logic signed [COORD_W-1:0] py,
    output hit_t                      hit
);

    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_W-1:0] ylo;
    logic signed [COORD_W-1:0] yhi;
    logic signed [COORD_W-1:0] xhi;
    logic signed [DW-1:0]      dpx;
    logic signed [DW-1:0]      dpy;
    logic signed [DW-1:0]      dx;
    logic signed [DW-1:0]      dy;
    logic signed [PW-1:0]      lhs;
    logic signed [PW-1:0]      rhs;
    logic                      span;

    logic                      valid_reg;
    logic                      last_reg;
    logic                      span_reg;
    logic                      vert_reg;
    logic                      dypos_reg;
    logic signed [PW-1:0]      lhs_reg;
    logic signed [PW-1:0]      rhs_reg;
    logic                      left_hit;

    always_comb
    begin
        ylo  = (vert_a.y < vert_b.y) ? vert_a.y : vert_b.y;
        yhi  = (vert_a.y > vert_b.y) ? vert_a.y : vert_b.y;
        xhi  = (vert_a.x > vert_b.x) ? vert_a.x : vert_b.x;
        dpx  = DW'(px) - DW'(vert_a.x);
        dpy  = DW'(py) - DW'(vert_a.y);
        dx   = DW'(vert_b.x) - DW'(vert_a.x);
        dy   = DW'(vert_b.y) - DW'(vert_a.y);
        lhs  = PW'(dpx) * PW'(dy);
        rhs  = PW'(dpy) * PW'(dx);
        span = (py > ylo) && (py <= yhi) && (px <= xhi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= edge_ctl.valid;
            last_reg  <= edge_ctl.valid && edge_ctl.last;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg  <= span;
        vert_reg  <= (vert_a.x == vert_b.x);
        dypos_reg <= (vert_b.y > vert_a.y);
        lhs_reg   <= lhs;
        rhs_reg   <= rhs;
    end

    // dy sign flips the strict-left comparison
    assign left_hit = vert_reg || (dypos_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg));

    assign hit.valid = valid_reg;
    assign hit.last  = last_reg;
    assign hit.hit   = span_reg && left_hit;

endmodule

// File: rtl/core/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test
// crossing-number point-in-polygon test over a loaded vertex table
// ----------------------------------------------------------------------------
//
//  channel | handshake          | contents
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | req_type, vertex_index, coord_x, coord_y
//  out     | out_valid/out_ready| inside_res, crossing_count
//  cfg     | cfg_we             | cfg_wdata -> vertex_count
//
//  a load word is written to the vertex ram on accept
//  a query walks n = min(vertex_count, MAX_VERTICES) edges, one ram read per
//  cycle over n+1 reads; each read passes the ram read register and one edge
//  register, and an empty polygon (n of 0) goes straight to the result
//  the single ram read port sets the rate of one edge per cycle
//  in_ready is low while a query walks; a finished result sits in the
//  output register so the next word can be taken while it waits
//  reset clears control and vertex_count; the vertex table is not cleared
//
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // input word channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [5:0]                vertex_index,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    // result word channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      inside_res,
    output logic [COUNT_W-1:0]        crossing_count,
    // configuration
    input  logic                      cfg_we,
    input  logic [COUNT_W-1:0]        cfg_wdata
);

    // address width of the table, and a wider width for counts and compares
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int WW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_VERTICES);

    state_t                    state_reg, state_next;
    logic [COUNT_W-1:0]        vcount_reg;
    logic [WW-1:0]             n_reg, n_next;
    logic [WW-1:0]             rd_k_reg, rd_k_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      rd_valid_reg;
    logic                      rd_first_reg;
    logic                      rd_last_reg;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_load;
    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;
    vertex_t                   prev_reg;
    logic                      out_inside_reg;
    logic [COUNT_W-1:0]        out_count_reg;

    logic                      in_acc;
    logic                      load_acc;
    logic                      query_acc;
    logic [WW-1:0]             idx_ext;
    logic [WW-1:0]             cnt_ext;
    logic [WW-1:0]             n_sat;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    vertex_t                   wr_data;
    logic                      rd_en;
    logic                      rd_is_last;
    logic [AW-1:0]             rd_addr;
    vertex_t                   rd_data;
    edge_ctl_t                 edge_ctl;
    hit_t                      hit;

    // ---------------------------------------------------------------- intake
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign load_acc  = in_acc && (req_type == REQ_LOAD);
    assign query_acc = in_acc && (req_type == REQ_QUERY);

    // loads to slots past the table are dropped
    assign idx_ext   = WW'(vertex_index);
    assign wr_en     = load_acc && (idx_ext < MAX_W);
    assign wr_addr   = idx_ext[AW-1:0];
    assign wr_data.x = coord_x;
    assign wr_data.y = coord_y;

    // vertex count in use, held to the table size
    assign cnt_ext = WW'(vcount_reg);
    assign n_sat   = (cnt_ext > MAX_W) ? MAX_W : cnt_ext;

    // ------------------------------------------------------------- table walk
    // reads go 0, 1, .. n-1 and then 0 again so the closing edge comes last;
    // writes only happen in idle, so reads and writes never meet
    assign rd_en      = (state_reg == ST_WALK);
    assign rd_is_last = (rd_k_reg == n_reg);
    assign rd_addr    = rd_is_last ? '0 : rd_k_reg[AW-1:0];

    pip_ram #(
        .WIDTH ($bits(vertex_t)),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // each read after the first closes an edge with the previous vertex
    assign edge_ctl.valid = rd_valid_reg && !rd_first_reg;
    assign edge_ctl.last  = rd_last_reg;

    pip_edge u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .edge_ctl (edge_ctl),
        .vert_a   (prev_reg),
        .vert_b   (rd_data),
        .px       (px_reg),
        .py       (py_reg),
        .hit      (hit)
    );

    // ------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        rd_k_next      = rd_k_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_load       = 1'b0;

        // running count of crossings, advanced as verdicts come back
        if (hit.valid)
        begin
            count_next = count_reg + COUNT_W'(hit.hit);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (query_acc)
                begin
                    n_next     = n_sat;
                    rd_k_next  = '0;
                    count_next = '0;
                    // empty polygon goes straight to the result
                    state_next = (n_sat == '0) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK:
            begin
                rd_k_next = rd_k_reg + 1'b1;
                if (rd_is_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (hit.valid && hit.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= '0;
            n_reg         <= '0;
            rd_k_reg      <= '0;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            rd_k_reg      <= rd_k_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_en;
            rd_first_reg  <= rd_en && (rd_k_reg == '0);
            rd_last_reg   <= rd_en && rd_is_last;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rd_valid_reg)
        begin
            prev_reg <= rd_data;
        end
        if (out_load)
        begin
            out_inside_reg <= count_reg[0];
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign inside_res     = out_inside_reg;
    assign crossing_count = out_count_reg;

    // ------------------------------------------------------------ assertions
    a_hit_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        hit.valid |-> (state_reg == ST_WALK || state_reg == ST_DRAIN))
        else $error("edge verdict outside a table walk");

    a_last_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (hit.valid && hit.last) |=> (state_reg == ST_DONE))
        else $error("last edge did not finish the query");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (WW'(count_reg) <= n_reg))
        else $error("crossing count above edge count");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("table read and write in the same cycle");

    a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (rd_k_reg <= n_reg))
        else $error("walk ran past the vertex count");

endmodule

// File: tb/tb_point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test
// self-checking bench for the crossing-number point-in-polygon block
// ----------------------------------------------------------------------------
//
//  a short table of directed words runs first: the empty polygon after reset,
//  a square spanning the full coordinate range, and a triangle whose edges
//  rise and fall so that both signs of the cross-multiplication are used
//  after that a series of phases each sets vertex_count, rebuilds the first
//  vertices in a coordinate span, and then sends a random mix of vertex
//  loads and point queries; query points are often lifted from the table so
//  that rays graze vertices and run along edges
//  every query is predicted from a local copy of the vertex table and the
//  count register, and each result word is checked against the oldest
//  prediction; the sender and receiver idle at rates set per phase
//
module tb_point_in_polygon_test;
    import pip_pkg::*;

    localparam int MAX_VERTICES   = 64;
    localparam int HALF_PERIOD    = 5;
    // settle margin: covers a full table walk and the pipeline drain
    localparam int SETTLE_CYCLES  = MAX_VERTICES + 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int REPORT_LIMIT   = 10;
    localparam int NO_WRITE       = -1;
    localparam int N_DIRECTED     = 23;
    localparam int N_PHASES       = 13;

    // coordinate spread used when building polygons and picking points
    typedef enum int {
        SPAN_TINY,
        SPAN_MID,
        SPAN_FULL
    } span_t;

    typedef struct packed {
        bit                 in_poly;
        logic [COUNT_W-1:0] count;
    } verdict_t;

    // one directed word; typed rows carry their own expected result
    typedef struct packed {
        int   set_count;
        logic req;
        int   idx;
        int   x;
        int   y;
        bit   typed;
        bit   t_inside;
        int   t_count;
    } dir_row_t;

    typedef struct packed {
        int    vcount;
        int    send_pct;
        int    recv_pct;
        span_t span;
        int    words;
        bit    squeeze;
    } phase_t;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic               req_type       = REQ_LOAD;
    logic [5:0]         vertex_index   = '0;
    logic [COORD_W-1:0] coord_x        = '0;
    logic [COORD_W-1:0] coord_y        = '0;
    logic               out_valid;
    logic               out_ready      = 1'b0;
    logic               inside_res;
    logic [COUNT_W-1:0] crossing_count;
    logic               cfg_we         = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata      = '0;

    // local copy of the block state
    vertex_t            shadow_table [MAX_VERTICES];
    logic [COUNT_W-1:0] vertex_count_shadow = '0;

    verdict_t pending_verdicts [$];
    int       mismatch_count = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    bit       hold_request   = 1'b0;
    int       hold_left      = 0;
    int       quiet_cycles   = 0;

    dir_row_t directed_rows [N_DIRECTED] = '{
        // empty polygon right after reset, ordinary and extreme point
        '{NO_WRITE, REQ_QUERY,  0,      0,      0, 1'b1, 1'b0, 0},
        '{NO_WRITE, REQ_QUERY, 63, -32768,  32767, 1'b1, 1'b0, 0},
        // square over the whole coordinate range
        '{NO_WRITE, REQ_LOAD,   0, -32768, -32768, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_LOAD,   1,  32767, -32768, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_LOAD,   2,  32767,  32767, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_LOAD,   3, -32768,  32767, 1'b0, 1'b0, 0},
        // origin crosses only the right-hand vertical edge
        '{4,        REQ_QUERY,  0,      0,      0, 1'b1, 1'b1, 1},
        '{NO_WRITE, REQ_QUERY,  0,  32767,  32767, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_QUERY,  0, -32768,      0, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_QUERY,  0,      0, -32768, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_QUERY,  0,  32767,      0, 1'b0, 1'b0, 0},
        // triangle with a rising and a falling slanted edge
        '{NO_WRITE, REQ_LOAD,   0,      0,      0, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_LOAD,   1,    100,     50, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_LOAD,   2,      0,    100, 1'b0, 1'b0, 0},
        '{3,        REQ_QUERY,  0,     10,     50, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_QUERY,  0,     50,     25, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_QUERY,  0,     50,     75, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_QUERY,  0,    100,     50, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_QUERY,  0,    101,     50, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_QUERY,  0,     -1,    100, 1'b0, 1'b0, 0},
        '{NO_WRITE, REQ_QUERY,  0, -32768,     50, 1'b0, 1'b0, 0},
        // back to an empty polygon with vertices still loaded
        '{0,        REQ_QUERY,  0,      5,      5, 1'b1, 1'b0, 0},
        '{NO_WRITE, REQ_LOAD,  63,  32767, -32768, 1'b0, 1'b0, 0}
    };

    // count 127 checks saturation, 0 the empty polygon, 1 and 2 degenerate
    // outlines; squeeze phases hold the receiver off while queries pile up
    phase_t phases [N_PHASES] = '{
        '{  4,  0,  0, SPAN_TINY, 40, 1'b0},
        '{ 64, 57,  0, SPAN_MID,  40, 1'b0},
        '{127,  0, 57, SPAN_FULL, 40, 1'b0},
        '{  3, 21, 21, SPAN_TINY, 50, 1'b0},
        '{  0,  0,  0, SPAN_MID,  20, 1'b0},
        '{  1, 57,  0, SPAN_TINY, 25, 1'b0},
        '{  2,  0, 57, SPAN_TINY, 30, 1'b0},
        '{ 16, 21, 21, SPAN_TINY, 50, 1'b0},
        '{ 64,  0,  0, SPAN_FULL, 40, 1'b1},
        '{ 65, 21, 21, SPAN_MID,  40, 1'b0},
        '{  7,  0,  0, SPAN_MID,  50, 1'b1},
        '{ 32,  0, 57, SPAN_TINY, 40, 1'b0},
        '{  5, 57,  0, SPAN_FULL, 35, 1'b0}
    };

    point_in_polygon_test #(
        .MAX_VERTICES(MAX_VERTICES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .vertex_index(vertex_index),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .inside_res(inside_res),
        .crossing_count(crossing_count),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // does the ray from (px,py) toward +x cross the edge a-b
    function automatic bit ray_hits_edge(vertex_t a, vertex_t b, longint px, longint py);
        longint x1, y1, x2, y2;
        longint y_lo, y_hi, x_hi, dy, lhs, rhs;
        x1 = $signed(a.x);
        y1 = $signed(a.y);
        x2 = $signed(b.x);
        y2 = $signed(b.y);
        y_lo = (y1 < y2) ? y1 : y2;
        y_hi = (y1 > y2) ? y1 : y2;
        x_hi = (x1 > x2) ? x1 : x2;
        // half-open in y so a vertex on the ray counts once
        if (!(py > y_lo && py <= y_hi))
            return 1'b0;
        if (px > x_hi)
            return 1'b0;
        if (x1 == x2)
            return 1'b1;
        // strictly left of the intersection, sign of dy flips the compare
        dy  = y2 - y1;
        lhs = (px - x1) * dy;
        rhs = (py - y1) * (x2 - x1);
        return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function automatic int count_ray_crossings(longint px, longint py);
        int n, hits, nxt;
        n = (vertex_count_shadow > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_shadow);
        hits = 0;
        for (int i = 0; i < n; i++)
        begin
            nxt = (i + 1 == n) ? 0 : i + 1;
            if (ray_hits_edge(shadow_table[6'(i)], shadow_table[6'(nxt)], px, py))
                hits++;
        end
        return hits;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [COORD_W-1:0] random_coord(span_t span);
        int c;
        case (span)
            SPAN_TINY: c = $urandom_range(16) - 8;
            SPAN_MID:  c = $urandom_range(4000) - 2000;
            default:
            begin
                if ($urandom_range(9) == 0)
                    c = $urandom_range(1) ? 32767 : -32768;
                else
                    c = $urandom();
            end
        endcase
        return c[COORD_W-1:0];
    endfunction

    // offer one word, wait for the handshake, then update the prediction
    task automatic issue_word(input logic req, input logic [5:0] idx,
                              input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input bit typed, input bit t_inside,
                              input logic [COUNT_W-1:0] t_count);
        verdict_t v;
        int       hits;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        vertex_index <= idx;
        coord_x      <= x;
        coord_y      <= y;
        do
            @(posedge clk);
        while (!in_ready);
        // word accepted at this edge
        if (req == REQ_LOAD)
            shadow_table[idx] = {y, x};
        else
        begin
            if (typed)
            begin
                v.in_poly = t_inside;
                v.count   = t_count;
            end
            else
            begin
                hits      = count_ray_crossings($signed(x), $signed(y));
                v.in_poly = hits[0];
                v.count   = hits[COUNT_W-1:0];
            end
            pending_verdicts.push_back(v);
        end
    endtask

    // stop sending until every result is back and the block has gone quiet
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [COUNT_W-1:0] value);
        wait_results_done();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        vertex_count_shadow = value;
    endtask

    task automatic note_mismatch(input string msg);
        if (mismatch_count < REPORT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // result checker: oldest prediction against each accepted result word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_result
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
                note_mismatch($sformatf("result word with nothing pending: inside %0b count %0d",
                                        inside_res, crossing_count));
            else
            begin
                want = pending_verdicts.pop_front();
                if (inside_res !== want.in_poly || crossing_count !== want.count)
                    note_mismatch($sformatf("expected inside %0b count %0d, got inside %0b count %0d",
                                            want.in_poly, want.count, inside_res, crossing_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any handshake ends the run
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        dir_row_t           row;
        phase_t             ph;
        int                 n_used;
        logic [COORD_W-1:0] px, py;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            if (row.set_count != NO_WRITE)
                write_vertex_count(row.set_count[COUNT_W-1:0]);
            issue_word(row.req, row.idx[5:0], row.x[COORD_W-1:0], row.y[COORD_W-1:0],
                       row.typed, row.t_inside, row.t_count[COUNT_W-1:0]);
        end

        // random phases
        foreach (phases[p])
        begin
            ph = phases[p];
            write_vertex_count(ph.vcount[COUNT_W-1:0]);
            send_idle_pct  = ph.send_pct;
            recv_stall_pct = ph.recv_pct;
            n_used = (ph.vcount > MAX_VERTICES) ? MAX_VERTICES : ph.vcount;

            // fresh outline in this span so no query reads a stale slot
            for (int i = 0; i < n_used; i++)
                issue_word(REQ_LOAD, i[5:0], random_coord(ph.span), random_coord(ph.span),
                           1'b0, 1'b0, '0);

            for (int k = 0; k < ph.words; k++)
            begin
                // long receiver hold-off while queries keep coming
                if (ph.squeeze && k == ph.words / 3)
                    hold_request = 1'b1;
                // let everything drain mid-phase, now and then at random too
                if (k == ph.words / 2 || $urandom_range(49) == 0)
                    wait_results_done();

                if ($urandom_range(99) < 20)
                    issue_word(REQ_LOAD, 6'($urandom_range(63)), random_coord(ph.span),
                               random_coord(ph.span), 1'b0, 1'b0, '0);
                else
                begin
                    if (n_used > 0 && $urandom_range(99) < 30)
                    begin
                        // point on or next to the table's own coordinates
                        px = shadow_table[6'($urandom_range(n_used - 1))].x;
                        py = shadow_table[6'($urandom_range(n_used - 1))].y;
                        if ($urandom_range(1))
                            px = px + COORD_W'($urandom_range(2)) - COORD_W'(1);
                    end
                    else
                    begin
                        px = random_coord(ph.span);
                        py = random_coord(ph.span);
                    end
                    issue_word(REQ_QUERY, 6'($urandom_range(63)), px, py, 1'b0, 1'b0, '0);
                end
            end
        end

        wait_results_done();
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/pip_pkg.sv
rtl/core/pip_ram.sv
rtl/core/pip_edge.sv
rtl/core/point_in_polygon_test.sv
tb/tb_point_in_polygon_test.sv
